// File: rtl/core/rat_pkg.sv
// Shared types, constants and arithmetic helpers for the recombination allele transmitter.
// No dependencies; used by every module of the block but rat_fifo.
package rat_pkg;

	localparam int ALLELE_BITS_DEF = 8;
	localparam int DRAW_BITS_DEF   = 32;

	localparam int CFG_IDX_BITS = 2;
	localparam int SEED_BITS    = 15;
	localparam int ALLELE_W     = 8;
	localparam int FRAC_W       = 16;

	localparam int DRAW_Q_DEPTH = 4;
	localparam int ITEM_Q_DEPTH = 2;

	localparam logic [SEED_BITS-1:0] SEED_RESET = 15'd1;

	localparam logic [SEED_BITS-1:0] MOD_A = 15'd30269;
	localparam logic [SEED_BITS-1:0] MOD_B = 15'd30307;
	localparam logic [SEED_BITS-1:0] MOD_C = 15'd30323;

	localparam logic [7:0] MUL_A = 8'd171;
	localparam logic [7:0] MUL_B = 8'd172;
	localparam logic [7:0] MUL_C = 8'd170;

	localparam int DIV_A = 177;
	localparam int DIV_B = 176;
	localparam int DIV_C = 178;

	// Quotient by reciprocal: exact for all 15-bit operands at this shift
	localparam int QUOT_SHIFT = 23;
	localparam logic [15:0] RECIP_A = 16'(((1 << QUOT_SHIFT) + DIV_A - 1) / DIV_A);
	localparam logic [15:0] RECIP_B = 16'(((1 << QUOT_SHIFT) + DIV_B - 1) / DIV_B);
	localparam logic [15:0] RECIP_C = 16'(((1 << QUOT_SHIFT) + DIV_C - 1) / DIV_C);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SEED_A = 2'd0,
		REG_SEED_B = 2'd1,
		REG_SEED_C = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_NEXT  = 1'b0,
		KIND_FIRST = 1'b1
	} locus_kind_t;

	typedef logic [SEED_BITS-1:0] seed_t;

	typedef struct packed {
		seed_t a;
		seed_t b;
		seed_t c;
	} gen_state_t;

	typedef struct packed {
		locus_kind_t          kind;
		logic [FRAC_W-1:0]    thr;
		logic [ALLELE_W-1:0]  hap0;
		logic [ALLELE_W-1:0]  hap1;
		logic                 slot;
	} locus_t;

	function automatic logic [7:0] wh_quot(input seed_t v, input logic [15:0] recip);
		logic [30:0] p;
		p = 31'(v) * 31'(recip);
		return p[QUOT_SHIFT+7:QUOT_SHIFT];
	endfunction

	// mul*v - modulus*q, wrapped into 0..modulus-1
	function automatic seed_t wh_update(input seed_t v, input logic [7:0] q,
			input logic [7:0] mul, input seed_t modulus);
		logic [23:0] pv;
		logic [23:0] pq;
		logic [23:0] r;
		pv = 24'(v) * 24'(mul);
		pq = 24'(q) * 24'(modulus);
		if (pv >= pq) begin
			r = pv - pq;
		end else begin
			r = pv + 24'(modulus) - pq;
		end
		return r[SEED_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/rat_fifo.sv
// Small synchronous queue with flush, register-based storage.
// Generic; no package dependency. DEPTH must be a power of two, at least 2.
module rat_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             flush,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             vld,
	output logic [WIDTH-1:0] dout
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign vld  = (cnt_q != '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (flush) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !flush) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// File: rtl/core/rat_draw_gen.sv
// Wichmann-Hill draw generator that runs ahead of the items into a draw queue.
// Depends on rat_pkg and rat_fifo.
module rat_draw_gen #(
	parameter int DRAW_BITS = rat_pkg::DRAW_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rat_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  rat_pkg::seed_t                    cfg_wdata,
	input  logic                              pop,
	output logic                              vld,
	output logic [DRAW_BITS-1:0]              draw
);
	import rat_pkg::*;

	localparam int CW = $clog2(DRAW_Q_DEPTH + 1);
	localparam int QW = DRAW_BITS + $bits(gen_state_t);
	localparam logic [63:0] ONE64 = 64'd1;
	localparam logic [DRAW_BITS-1:0] W_A =
		DRAW_BITS'(((ONE64 << (DRAW_BITS + 1)) + 64'(MOD_A)) / (64'd2 * 64'(MOD_A)));
	localparam logic [DRAW_BITS-1:0] W_B =
		DRAW_BITS'(((ONE64 << (DRAW_BITS + 1)) + 64'(MOD_B)) / (64'd2 * 64'(MOD_B)));
	localparam logic [DRAW_BITS-1:0] W_C =
		DRAW_BITS'(((ONE64 << (DRAW_BITS + 1)) + 64'(MOD_C)) / (64'd2 * 64'(MOD_C)));

	gen_state_t             st_q;
	gen_state_t             cons_q;
	gen_state_t             st_s2;
	gen_state_t             pop_state;
	gen_state_t             cfg_state;
	logic                   phase_q;
	logic [7:0]             quot_a_q;
	logic [7:0]             quot_b_q;
	logic [7:0]             quot_c_q;
	logic                   upd_s1;
	logic                   prod_vld_s2;
	logic [DRAW_BITS-1:0]   prod_a_s2;
	logic [DRAW_BITS-1:0]   prod_b_s2;
	logic [DRAW_BITS-1:0]   prod_c_s2;
	logic [CW-1:0]          credit_q;
	logic                   start;
	logic                   q_full;
	logic [QW-1:0]          q_din;
	logic [QW-1:0]          q_dout;

	assign start     = !phase_q && !q_full && (credit_q < CW'(DRAW_Q_DEPTH));
	assign q_din     = {st_s2, DRAW_BITS'(prod_a_s2 + prod_b_s2 + prod_c_s2)};
	assign draw      = q_dout[DRAW_BITS-1:0];
	assign pop_state = q_dout[QW-1:DRAW_BITS];

	// rewind to the state of the last consumed draw, then load the seed
	always_comb begin
		cfg_state = cons_q;
		case (cfg_idx)
			REG_SEED_A: cfg_state.a = cfg_wdata;
			REG_SEED_B: cfg_state.b = cfg_wdata;
			REG_SEED_C: cfg_state.c = cfg_wdata;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '{a: SEED_RESET, b: SEED_RESET, c: SEED_RESET};
			cons_q      <= '{a: SEED_RESET, b: SEED_RESET, c: SEED_RESET};
			phase_q     <= 1'b0;
			upd_s1      <= 1'b0;
			prod_vld_s2 <= 1'b0;
			credit_q    <= '0;
		end else if (cfg_we) begin
			st_q        <= cfg_state;
			cons_q      <= cfg_state;
			phase_q     <= 1'b0;
			upd_s1      <= 1'b0;
			prod_vld_s2 <= 1'b0;
			credit_q    <= '0;
		end else begin
			if (pop) begin
				cons_q <= pop_state;
			end
			upd_s1      <= phase_q;
			prod_vld_s2 <= upd_s1;
			if (start) begin
				phase_q <= 1'b1;
			end
			if (phase_q) begin
				st_q.a  <= wh_update(st_q.a, quot_a_q, MUL_A, MOD_A);
				st_q.b  <= wh_update(st_q.b, quot_b_q, MUL_B, MOD_B);
				st_q.c  <= wh_update(st_q.c, quot_c_q, MUL_C, MOD_C);
				phase_q <= 1'b0;
			end
			credit_q <= credit_q + CW'(start) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_a_q <= wh_quot(st_q.a, RECIP_A);
			quot_b_q <= wh_quot(st_q.b, RECIP_B);
			quot_c_q <= wh_quot(st_q.c, RECIP_C);
		end
		if (upd_s1) begin
			prod_a_s2 <= DRAW_BITS'(st_q.a) * W_A;
			prod_b_s2 <= DRAW_BITS'(st_q.b) * W_B;
			prod_c_s2 <= DRAW_BITS'(st_q.c) * W_C;
			st_s2     <= st_q;
		end
	end

	rat_fifo #(
		.WIDTH(QW),
		.DEPTH(DRAW_Q_DEPTH)
	) u_draw_q (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (cfg_we),
		.push   (prod_vld_s2),
		.din    (q_din),
		.full   (q_full),
		.pop    (pop),
		.vld    (vld),
		.dout   (q_dout)
	);

endmodule

// File: rtl/core/rat_front.sv
// Input side: accepts loci, classifies first and later loci, masks alleles.
// Depends on rat_pkg; feeds the locus queue.
module rat_front #(
	parameter int ALLELE_BITS = rat_pkg::ALLELE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // allele_hap0, allele_hap1, recomb_fraction
	input  logic [1:0]       s_tuser,   // first_locus, from_mother
	input  logic             q_full,
	output logic             push,
	output rat_pkg::locus_t  entry
);
	import rat_pkg::*;

	localparam logic [ALLELE_W-1:0] AMASK = ALLELE_W'((64'd1 << ALLELE_BITS) - 64'd1);

	locus_t entry_q;
	logic   vld_q;

	assign push     = vld_q && !q_full;
	assign s_tready = !vld_q || !q_full;
	assign entry    = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_q <= 1'b1;
		end else if (push) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			entry_q.kind <= s_tuser[0] ? KIND_FIRST : KIND_NEXT;
			entry_q.hap0 <= s_tdata[7:0] & AMASK;
			entry_q.hap1 <= s_tdata[15:8] & AMASK;
			entry_q.thr  <= s_tdata[31:16];
			entry_q.slot <= s_tuser[1];
		end
	end

endmodule

// File: rtl/core/rat_back.sv
// Output side: pairs a queued locus with a draw, updates the haplotype side.
// Depends on rat_pkg; holds the output register.
module rat_back #(
	parameter int DRAW_BITS = rat_pkg::DRAW_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_vld,
	input  rat_pkg::locus_t       item,
	output logic                  item_pop,
	input  logic                  draw_vld,
	input  logic [DRAW_BITS-1:0]  draw,
	output logic                  draw_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // allele
	output logic [1:0]            m_tuser   // side_taken, child_slot
);
	import rat_pkg::*;

	logic                 go;
	logic                 side_q;
	logic                 side_nxt;
	logic                 out_vld_q;
	logic                 slot_q;
	logic [ALLELE_W-1:0]  allele_q;
	logic [DRAW_BITS-1:0] thr_ext;

	assign go       = item_vld && draw_vld && (!out_vld_q || m_tready);
	assign item_pop = go;
	assign draw_pop = go;
	assign thr_ext  = DRAW_BITS'(item.thr) << (DRAW_BITS - FRAC_W);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = allele_q;
	assign m_tuser  = {slot_q, side_q};

	always_comb begin
		case (item.kind)
			KIND_FIRST: side_nxt = draw[DRAW_BITS-1];
			KIND_NEXT:  side_nxt = side_q ^ (draw <= thr_ext);
			default:    side_nxt = side_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (go) begin
			side_q    <= side_nxt;
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			allele_q <= side_nxt ? item.hap1 : item.hap0;
			slot_q   <= item.slot;
		end
	end

endmodule

// File: rtl/core/recombination_allele_transmitter.sv
// Path: accepted locus -> front register -> locus queue -> output register, once a draw is queued.
// Throughput: the sustained rate is set by the generator step (quotient, then update);
// up to 4 queued draws allow short bursts at 1 per cycle while m_tready is held high.
// Reset: asynchronous, clears control; generator state and seeds go to 1, side to 0.
// The draw queue refills after reset and after each seed write, which flushes it.
module recombination_allele_transmitter #(
	parameter int ALLELE_BITS = rat_pkg::ALLELE_BITS_DEF,
	parameter int DRAW_BITS   = rat_pkg::DRAW_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rat_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [rat_pkg::SEED_BITS-1:0]     cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // allele_hap0, allele_hap1, recomb_fraction
	input  logic [1:0]                        s_tuser,  // first_locus, from_mother
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // allele
	output logic [1:0]                        m_tuser   // side_taken, child_slot
);
	import rat_pkg::*;

	localparam int LW = $bits(locus_t);

	locus_t               front_entry;
	locus_t               back_entry;
	logic                 front_push;
	logic                 item_q_full;
	logic                 item_vld;
	logic                 item_pop;
	logic [LW-1:0]        item_dout;
	logic                 draw_vld;
	logic                 draw_pop;
	logic [DRAW_BITS-1:0] draw;

	assign back_entry = item_dout;

	rat_draw_gen #(
		.DRAW_BITS(DRAW_BITS)
	) u_draw_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pop       (draw_pop),
		.vld       (draw_vld),
		.draw      (draw)
	);

	rat_front #(
		.ALLELE_BITS(ALLELE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (item_q_full),
		.push     (front_push),
		.entry    (front_entry)
	);

	rat_fifo #(
		.WIDTH(LW),
		.DEPTH(ITEM_Q_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (1'b0),
		.push   (front_push),
		.din    (front_entry),
		.full   (item_q_full),
		.pop    (item_pop),
		.vld    (item_vld),
		.dout   (item_dout)
	);

	rat_back #(
		.DRAW_BITS(DRAW_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (item_vld),
		.item     (back_entry),
		.item_pop (item_pop),
		.draw_vld (draw_vld),
		.draw     (draw),
		.draw_pop (draw_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_pop_has_draw: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> draw_vld)
		else $error("locus taken without a queued draw");

	a_seed_write_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !draw_vld)
		else $error("stale draw survived a seed write");

	a_output_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(item_pop))
		else $error("output valid without a consumed locus");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for recombination_allele_transmitter: directed loci from a stimulus table, then
// random transmissions, checked item by item against a local crossover predictor; typed
// rows are checked against the table. Depends on rat_pkg and the RTL of the block only.
module tb;
	import rat_pkg::*;

	localparam int SUB_A = 2;
	localparam int SUB_B = 35;
	localparam int SUB_C = 63;
	localparam bit [63:0] W_A = ((64'd1 << 33) + 64'(MOD_A)) / (64'd2 * 64'(MOD_A));
	localparam bit [63:0] W_B = ((64'd1 << 33) + 64'(MOD_B)) / (64'd2 * 64'(MOD_B));
	localparam bit [63:0] W_C = ((64'd1 << 33) + 64'(MOD_C)) / (64'd2 * 64'(MOD_C));
	localparam logic [31:0] HALF_DRAW = 32'h8000_0000;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 190;

	typedef struct packed {
		logic [ALLELE_W-1:0] allele;
		logic                side;
		logic                slot;
	} handoff_t;

	typedef enum logic {
		ROW_SEED  = 1'b0,
		ROW_LOCUS = 1'b1
	} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CFG_IDX_BITS-1:0]   reg_idx;
		seed_t                     reg_val;
		locus_t                    lc;
		bit                        typed;
		handoff_t                  want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_BITS-1:0]   cfg_idx;
	logic [SEED_BITS-1:0]      cfg_wdata;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [31:0]               s_tdata;
	logic [1:0]                s_tuser;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [7:0]                m_tdata;
	logic [1:0]                m_tuser;

	seed_t      gen_a;
	seed_t      gen_b;
	seed_t      gen_c;
	logic       hap_side;
	handoff_t   expected_handoffs[$];
	stim_row_t  directed[$];
	int         errors;
	int         loci_sent;
	int         handoffs_seen;
	int         crossovers;
	int         transmissions;
	int         seed_writes;
	int         send_idle_pct;
	int         recv_idle_pct;

	recombination_allele_transmitter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report(input string msg);
		$display("[%0t] %s", $time, msg);
		errors++;
	endtask

	function automatic seed_t wh_advance(input seed_t x, input int q, input int mul,
			input int sub, input int m);
		int v;
		int r;
		v = x;
		r = (v % q) * mul - (v / q) * sub;
		if (r < 0) begin
			r += m;
		end
		return seed_t'(r);
	endfunction

	function automatic handoff_t transmit_locus(input locus_t lc);
		logic [63:0] mix;
		logic [31:0] draw;
		handoff_t h;
		gen_a = wh_advance(gen_a, DIV_A, MUL_A, SUB_A, MOD_A);
		gen_b = wh_advance(gen_b, DIV_B, MUL_B, SUB_B, MOD_B);
		gen_c = wh_advance(gen_c, DIV_C, MUL_C, SUB_C, MOD_C);
		mix = gen_a * W_A + gen_b * W_B + gen_c * W_C;
		draw = mix[31:0];
		if (lc.kind == KIND_FIRST) begin
			hap_side = (draw < HALF_DRAW) ? 1'b0 : 1'b1;
			transmissions++;
		end else if (draw <= {lc.thr, 16'h0000}) begin
			hap_side = ~hap_side;
			crossovers++;
		end
		h.allele = hap_side ? lc.hap1 : lc.hap0;
		h.side = hap_side;
		h.slot = lc.slot;
		return h;
	endfunction

	function automatic int idle_gap(input int pct);
		return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 12)) : 0;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 30;
			default: return 90;
		endcase
	endfunction

	function automatic seed_t pick_seed(input int m);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return seed_t'(1);
			2: return seed_t'(m - 1);
			3: return seed_t'($urandom_range(m, 32767));
			default: return seed_t'($urandom_range(1, m - 1));
		endcase
	endfunction

	function automatic logic [FRAC_W-1:0] pick_frac();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 16));
			3: return 16'($urandom_range(16'h7F00, 16'h80FF));
			4, 5: return 16'($urandom_range(0, 16'h0FFF));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic stim_row_t seed_row(input logic [CFG_IDX_BITS-1:0] idx,
			input seed_t val);
		stim_row_t r;
		r = '{kind: ROW_SEED, reg_idx: idx, reg_val: val, lc: '0, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t locus_row(input locus_kind_t kind, input logic [7:0] h0,
			input logic [7:0] h1, input logic [15:0] thr, input logic slot);
		stim_row_t r;
		r = '{kind: ROW_LOCUS, reg_idx: '0, reg_val: '0, lc: '0, typed: 1'b0, want: '0};
		r.lc.kind = kind;
		r.lc.hap0 = h0;
		r.lc.hap1 = h1;
		r.lc.thr = thr;
		r.lc.slot = slot;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input locus_kind_t kind, input logic [7:0] h0,
			input logic [7:0] h1, input logic [15:0] thr, input logic slot,
			input logic [7:0] allele, input logic side);
		stim_row_t r;
		r = locus_row(kind, h0, h1, thr, slot);
		r.typed = 1'b1;
		r.want = '{allele: allele, side: side, slot: slot};
		return r;
	endfunction

	task automatic push_locus(input locus_t lc, input bit typed, input handoff_t want);
		int gap;
		handoff_t h;
		gap = idle_gap(send_idle_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {lc.thr, lc.hap1, lc.hap0};
		s_tuser <= {lc.slot, lc.kind};
		do @(posedge clk); while (!s_tready);
		h = transmit_locus(lc);
		expected_handoffs.push_back(typed ? want : h);
		loci_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_handoffs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input seed_t val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_SEED_A: gen_a = val;
			REG_SEED_B: gen_b = val;
			REG_SEED_C: gen_c = val;
			default: ;
		endcase
		seed_writes++;
	endtask

	initial begin
		handoff_t want;
		handoff_t got;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			int gap;
			gap = idle_gap(recv_idle_pct);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = '{allele: m_tdata, side: m_tuser[0], slot: m_tuser[1]};
			handoffs_seen++;
			if (expected_handoffs.size() == 0) begin
				report($sformatf("result with nothing pending: allele %02h side %0d slot %0d",
					got.allele, got.side, got.slot));
			end else begin
				want = expected_handoffs.pop_front();
				if (got.allele !== want.allele)
					report($sformatf("result %0d allele %02h, want %02h",
						handoffs_seen, got.allele, want.allele));
				if (got.side !== want.side)
					report($sformatf("result %0d side_taken %0d, want %0d",
						handoffs_seen, got.side, want.side));
				if (got.slot !== want.slot)
					report($sformatf("result %0d child_slot %0d, want %0d",
						handoffs_seen, got.slot, want.slot));
			end
		end
	end

	initial begin
		bit cfg_open;
		int sent;
		int len;
		bit noise;
		logic mother;
		locus_t lc;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		errors = 0;
		loci_sent = 0;
		handoffs_seen = 0;
		crossovers = 0;
		transmissions = 0;
		seed_writes = 0;
		send_idle_pct = 30;
		recv_idle_pct = 30;
		gen_a = SEED_RESET;
		gen_b = SEED_RESET;
		gen_c = SEED_RESET;
		hap_side = 1'b0;

		directed.push_back(typed_row(KIND_NEXT, 8'h00, 8'hFF, 16'h0000, 1'b0, 8'h00, 1'b0));
		directed.push_back(locus_row(KIND_FIRST, 8'hA5, 8'h5A, 16'h0000, 1'b1));
		directed.push_back(locus_row(KIND_NEXT, 8'hFF, 8'h00, 16'hFFFF, 1'b1));
		directed.push_back(locus_row(KIND_NEXT, 8'h55, 8'hAA, 16'h0001, 1'b0));
		directed.push_back(locus_row(KIND_NEXT, 8'hAA, 8'h55, 16'h8000, 1'b0));
		directed.push_back(locus_row(KIND_NEXT, 8'h0F, 8'hF0, 16'h7FFF, 1'b1));
		directed.push_back(locus_row(KIND_FIRST, 8'hFF, 8'hFF, 16'hFFFF, 1'b0));
		directed.push_back(seed_row(REG_SEED_A, 15'd0));
		directed.push_back(seed_row(REG_SEED_B, 15'd0));
		directed.push_back(seed_row(REG_SEED_C, 15'd0));
		directed.push_back(typed_row(KIND_FIRST, 8'h3C, 8'hC3, 16'hFFFF, 1'b0, 8'h3C, 1'b0));
		directed.push_back(typed_row(KIND_NEXT, 8'h3C, 8'hC3, 16'h0000, 1'b0, 8'hC3, 1'b1));
		directed.push_back(typed_row(KIND_NEXT, 8'h00, 8'hFF, 16'hFFFF, 1'b1, 8'h00, 1'b0));
		directed.push_back(typed_row(KIND_NEXT, 8'h00, 8'hFF, 16'h0000, 1'b1, 8'hFF, 1'b1));
		directed.push_back(seed_row(REG_UNUSED, 15'h7FFF));
		directed.push_back(typed_row(KIND_NEXT, 8'h12, 8'h34, 16'h0000, 1'b0, 8'h12, 1'b0));
		directed.push_back(typed_row(KIND_FIRST, 8'h12, 8'h34, 16'h0000, 1'b1, 8'h12, 1'b0));
		directed.push_back(seed_row(REG_SEED_A, 15'h7FFF));
		directed.push_back(seed_row(REG_SEED_B, 15'(MOD_B)));
		directed.push_back(seed_row(REG_SEED_C, 15'(MOD_C - 1)));
		directed.push_back(locus_row(KIND_FIRST, 8'h80, 8'h01, 16'h0000, 1'b0));
		directed.push_back(locus_row(KIND_NEXT, 8'h01, 8'h80, 16'hFFFF, 1'b1));
		directed.push_back(locus_row(KIND_NEXT, 8'hFE, 8'h7F, 16'h0001, 1'b0));
		directed.push_back(locus_row(KIND_NEXT, 8'h7F, 8'hFE, 16'h8000, 1'b1));
		directed.push_back(locus_row(KIND_NEXT, 8'hC0, 8'h03, 16'h0000, 1'b0));
		directed.push_back(locus_row(KIND_NEXT, 8'h03, 8'hC0, 16'hFFFE, 1'b1));
		directed.push_back(seed_row(REG_SEED_A, 15'(MOD_A - 1)));
		directed.push_back(seed_row(REG_SEED_B, 15'd1));
		directed.push_back(seed_row(REG_SEED_C, 15'h4000));
		directed.push_back(locus_row(KIND_FIRST, 8'h69, 8'h96, 16'h4000, 1'b1));
		directed.push_back(locus_row(KIND_NEXT, 8'h96, 8'h69, 16'hC000, 1'b1));
		directed.push_back(locus_row(KIND_NEXT, 8'h24, 8'hDB, 16'h2000, 1'b0));
		directed.push_back(locus_row(KIND_NEXT, 8'hDB, 8'h24, 16'hE000, 1'b0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		cfg_open = 1'b0;
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_SEED) begin
				if (!cfg_open) begin
					drain_results();
					cfg_open = 1'b1;
				end
				cfg_write(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				push_locus(directed[i].lc, directed[i].typed, directed[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			cfg_write(REG_SEED_A, pick_seed(MOD_A));
			cfg_write(REG_SEED_B, pick_seed(MOD_B));
			cfg_write(REG_SEED_C, pick_seed(MOD_C));
			if ($urandom_range(0, 3) == 0) begin
				cfg_write(REG_UNUSED, seed_t'($urandom));
			end
			cfg_we <= 1'b0;
			send_idle_pct = pick_pct();
			recv_idle_pct = pick_pct();
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 39) == 0) begin
					drain_results();
				end
				noise = ($urandom_range(0, 9) == 0);
				len = $urandom_range(1, 24);
				if (len > ITEMS_PER_PHASE - sent) begin
					len = ITEMS_PER_PHASE - sent;
				end
				mother = 1'($urandom_range(0, 1));
				for (int k = 0; k < len; k++) begin
					lc.kind = (k == 0) ? KIND_FIRST : KIND_NEXT;
					lc.slot = mother;
					if (noise) begin
						lc.kind = $urandom_range(0, 1) ? KIND_FIRST : KIND_NEXT;
						lc.slot = 1'($urandom_range(0, 1));
					end
					lc.hap0 = 8'($urandom);
					lc.hap1 = 8'($urandom);
					lc.thr = pick_frac();
					push_locus(lc, 1'b0, '0);
					sent++;
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_handoffs.size() != 0) begin
			report($sformatf("%0d expected results never arrived", expected_handoffs.size()));
		end
		$display("Covered %0d loci in %0d transmissions with %0d crossovers, %0d seed writes",
			loci_sent, transmissions, crossovers, seed_writes);
		$display("Checked %0d results, %0d mismatches", handoffs_seen, errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
